/* src/ffba_pkg.sv */
// Shared constants and types for the first-fit block allocator.
package ffba_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned POOL_BYTES  = 4096;
    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned NBLK        = POOL_BYTES / BLOCK_BYTES;
    localparam int unsigned IDX_W       = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int unsigned NEED_W      = $clog2(NBLK + 1);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MARK_FREE  = 2'd0,
        MARK_CONT  = 2'd1,
        MARK_START = 2'd3
    } mark_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [NEED_W-1:0] need;
        logic [IDX_W-1:0]  idx;
    } cmd_t;

endpackage

/* src/ffba_if.sv */
// Channel interfaces: request, response and configuration write.
interface ffba_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [ffba_pkg::SIZE_W-1:0]    size_bytes;
    logic [ffba_pkg::ADDR_W-1:0]    free_address;

    modport source (output valid, output req_type, output size_bytes, output free_address,
                    input ready);
    modport sink   (input valid, input req_type, input size_bytes, input free_address,
                    output ready);
endinterface

interface ffba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [ffba_pkg::ADDR_W-1:0]    grant_address;

    modport source (output valid, output ok, output grant_address, input ready);
    modport sink   (input valid, input ok, input grant_address, output ready);
endinterface

interface ffba_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::ADDR_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator.
//
//  channel  dir  handshake      word
//  cfg      in   valid/ready    data: pool_base
//  req      in   valid/ready    req_type, size_bytes, free_address
//  rsp      out  valid/ready    ok, grant_address
//
// A word waits in the queue until the back end is idle and rsp is free, then is popped.
// Allocate: block marks are scanned in order (up to 256), then each run block is marked.
// Free: the start mark is checked, then blocks are released up to the end of the run or
// the last block; a free with no start mark is refused. Result is registered.
// Block map is read one mark a cycle (one read, one write port); this sets the rate.
// Reset clears all marks at once through per-block valid bits; no clearing pass.
// A two-word queue lets req be taken while the back end works or rsp stalls.
module first_fit_block_allocator (
    input  logic     clk,
    input  logic     rst_n,
    ffba_cfg_if.sink cfg,
    ffba_req_if.sink req,
    ffba_rsp_if.source rsp
);

    logic [ffba_pkg::ADDR_W-1:0] pool_base_reg;
    logic                        push_valid;
    logic                        push_ready;
    ffba_pkg::cmd_t              push_data;
    logic                        pop_valid;
    logic                        pop_ready;
    ffba_pkg::cmd_t              pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            pool_base_reg <= cfg.data;
        end
    end

    ffba_front u_front (
        .req        (req),
        .pool_base  (pool_base_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ffba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ffba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_base (pool_base_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

/* src/ffba_front.sv */
// Front end: checks each request word and turns it into a queued command.
module ffba_front (
    ffba_req_if.sink                    req,
    input  logic [ffba_pkg::ADDR_W-1:0] pool_base,
    output logic                        push_valid,
    input  logic                        push_ready,
    output ffba_pkg::cmd_t              push_data
);

    logic [ffba_pkg::ADDR_W-1:0] size_ext;
    logic [ffba_pkg::ADDR_W-1:0] need_full;
    logic [ffba_pkg::ADDR_W-1:0] off;
    logic [ffba_pkg::ADDR_W-1:0] quot;
    logic [ffba_pkg::ADDR_W-1:0] rem;
    logic                        size_ok;
    logic                        addr_ok;

    assign size_ext  = ffba_pkg::ADDR_W'(req.size_bytes);
    assign need_full = (size_ext + ffba_pkg::ADDR_W'(ffba_pkg::BLOCK_BYTES - 1))
                       / ffba_pkg::BLOCK_BYTES;
    assign size_ok   = (size_ext != '0) && (size_ext <= ffba_pkg::ADDR_W'(ffba_pkg::POOL_BYTES));

    assign off     = req.free_address - pool_base;
    assign quot    = off / ffba_pkg::BLOCK_BYTES;
    assign rem     = off % ffba_pkg::BLOCK_BYTES;
    assign addr_ok = (req.free_address != '0) && (req.free_address >= pool_base)
                     && (rem == '0) && (quot < ffba_pkg::ADDR_W'(ffba_pkg::NBLK));

    always_comb
    begin
        push_data.need = need_full[ffba_pkg::NEED_W-1:0];
        push_data.idx  = quot[ffba_pkg::IDX_W-1:0];
        if (req.req_type == 1'b0)
        begin
            push_data.op = size_ok ? ffba_pkg::OP_ALLOC : ffba_pkg::OP_REJECT;
        end
        else
        begin
            push_data.op = addr_ok ? ffba_pkg::OP_FREE : ffba_pkg::OP_REJECT;
        end
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

/* src/ffba_queue.sv */
// Small command FIFO between the front end and the block-map sequencer.
module ffba_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ffba_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ffba_pkg::cmd_t pop_data
);

    ffba_pkg::cmd_t                 entry_reg [ffba_pkg::QUEUE_DEPTH];
    logic [ffba_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [ffba_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [ffba_pkg::QUEUE_CW-1:0]  count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != ffba_pkg::QUEUE_CW'(ffba_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ffba_pkg::QUEUE_AW'(ffba_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ffba_pkg::QUEUE_AW'(ffba_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/ffba_back.sv */
// Back end: block-map memory, first-fit scan, mark and release sequencer, result register.
module ffba_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ffba_pkg::ADDR_W-1:0] pool_base,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  ffba_pkg::cmd_t              pop_data,
    ffba_rsp_if.source                  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_CHECK,
        S_CONT
    } state_t;

    localparam logic [ffba_pkg::IDX_W-1:0] LAST_IDX = ffba_pkg::IDX_W'(ffba_pkg::NBLK - 1);

    ffba_pkg::mark_t              marks_mem [ffba_pkg::NBLK];
    logic [ffba_pkg::NBLK-1:0]    mark_vld_reg;
    ffba_pkg::mark_t              rd_mark_reg;
    logic                         rd_vld_reg;
    ffba_pkg::mark_t              mark_q;

    state_t                       state_reg, state_next;
    logic [ffba_pkg::IDX_W-1:0]   cur_reg, cur_next;
    logic [ffba_pkg::NEED_W-1:0]  run_reg, run_next;
    logic [ffba_pkg::NEED_W-1:0]  need_reg, need_next;
    logic [ffba_pkg::IDX_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ffba_pkg::IDX_W-1:0]   first_reg, first_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         ok_reg, ok_next;
    logic [ffba_pkg::ADDR_W-1:0]  grant_reg, grant_next;

    logic                         take;
    logic [ffba_pkg::NEED_W-1:0]  run_inc;
    logic [ffba_pkg::IDX_W-1:0]   rd_addr;
    logic                         we;
    logic [ffba_pkg::IDX_W-1:0]   wr_addr;
    ffba_pkg::mark_t              wr_mark;

    assign pop_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign take      = pop_valid && pop_ready;
    assign mark_q    = rd_vld_reg ? rd_mark_reg : ffba_pkg::MARK_FREE;
    assign run_inc   = (mark_q == ffba_pkg::MARK_FREE) ? run_reg + 1'b1 : '0;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        run_next       = run_reg;
        need_next      = need_reg;
        wr_ptr_next    = wr_ptr_reg;
        first_next     = first_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        ok_next        = ok_reg;
        grant_next     = grant_reg;
        rd_addr        = cur_reg + 1'b1;
        we             = 1'b0;
        wr_addr        = cur_reg;
        wr_mark        = ffba_pkg::MARK_FREE;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = (pop_data.op == ffba_pkg::OP_ALLOC) ? '0 : pop_data.idx;
                if (take)
                begin
                    unique case (pop_data.op)
                        ffba_pkg::OP_ALLOC:
                        begin
                            cur_next   = '0;
                            run_next   = '0;
                            need_next  = pop_data.need;
                            state_next = S_SCAN;
                        end
                        ffba_pkg::OP_FREE:
                        begin
                            cur_next   = pop_data.idx;
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            ok_next        = 1'b0;
                            grant_next     = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (run_inc == need_reg)
                begin
                    first_next  = cur_reg - ffba_pkg::IDX_W'(need_reg - 1'b1);
                    wr_ptr_next = cur_reg - ffba_pkg::IDX_W'(need_reg - 1'b1);
                    state_next  = S_MARK;
                end
                else if (cur_reg == LAST_IDX)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = 1'b0;
                    grant_next     = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                    run_next = run_inc;
                end
            end
            S_MARK:
            begin
                we      = 1'b1;
                wr_addr = wr_ptr_reg;
                wr_mark = (wr_ptr_reg == first_reg) ? ffba_pkg::MARK_START : ffba_pkg::MARK_CONT;
                if (wr_ptr_reg == cur_reg)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    grant_next     = pool_base + ffba_pkg::ADDR_W'(first_reg)
                                     * ffba_pkg::ADDR_W'(ffba_pkg::BLOCK_BYTES);
                    state_next     = S_IDLE;
                end
                else
                begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                if (mark_q != ffba_pkg::MARK_START)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = 1'b0;
                    grant_next     = '0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    we = 1'b1;
                    if (cur_reg == LAST_IDX)
                    begin
                        rsp_valid_next = 1'b1;
                        ok_next        = 1'b1;
                        grant_next     = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + 1'b1;
                        state_next = S_CONT;
                    end
                end
            end
            S_CONT:
            begin
                if ((mark_q == ffba_pkg::MARK_CONT) && (cur_reg != LAST_IDX))
                begin
                    we       = 1'b1;
                    cur_next = cur_reg + 1'b1;
                end
                else
                begin
                    we             = (mark_q == ffba_pkg::MARK_CONT);
                    rsp_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    grant_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            cur_reg       <= '0;
            run_reg       <= '0;
            need_reg      <= '0;
            wr_ptr_reg    <= '0;
            first_reg     <= '0;
            ok_reg        <= 1'b0;
            grant_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cur_reg       <= cur_next;
            run_reg       <= run_next;
            need_reg      <= need_next;
            wr_ptr_reg    <= wr_ptr_next;
            first_reg     <= first_next;
            ok_reg        <= ok_next;
            grant_reg     <= grant_next;
        end
    end

    // per-block valid bits: an unwritten block reads as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= mark_vld_reg[rd_addr];
            if (we)
            begin
                mark_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_mark_reg <= marks_mem[rd_addr];
        if (we)
        begin
            marks_mem[wr_addr] <= wr_mark;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = ok_reg;
    assign rsp.grant_address = grant_reg;

endmodule

/* test/first_fit_block_allocator_tb.sv */
// Self-checking testbench: random and directed request/response traffic checked against a block-mark model.
module first_fit_block_allocator_tb;

    import ffba_pkg::*;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_FREE    = 1'b1;
    localparam int   IDLE_LIMIT  = 5000;
    localparam int   TAIL_CYCLES = 600;
    localparam int   PHASE_WORDS = 150;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_address;
    } alloc_req_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] grant_address;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;

    ffba_cfg_if cfg_ch ();
    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    mark_t             mark_map [NBLK];
    logic [ADDR_W-1:0] model_base;
    alloc_req_t        pending_reqs [$];
    alloc_rsp_t        expected_rsps [$];
    logic [ADDR_W-1:0] live_grants [$];

    int  errors;
    int  n_grants;
    int  n_releases;
    int  n_refusals;
    int  n_bases;
    int  req_gap;
    int  rsp_wait;
    bit  req_quiet;
    bit  rsp_quiet;
    int  idle_cycles;

    always #5 clk = ~clk;

    // First-fit allocate or release against the shadow block map.
    function automatic alloc_rsp_t serve_request(logic rtype, logic [SIZE_W-1:0] size,
                                                 logic [ADDR_W-1:0] addr);
        alloc_rsp_t        res;
        int unsigned       need;
        int unsigned       run;
        int unsigned       first;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] idx;
        res = '0;
        if (rtype == REQ_ALLOC)
        begin
            if (size != 0 && size <= POOL_BYTES)
            begin
                need = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                run  = 0;
                for (int k = 0; k < NBLK; k++)
                begin
                    if (mark_map[k] == MARK_FREE)
                        run++;
                    else
                        run = 0;
                    if (run == need)
                    begin
                        first = k - (need - 1);
                        mark_map[first] = MARK_START;
                        for (int j = first + 1; j <= k; j++)
                            mark_map[j] = MARK_CONT;
                        res.ok = 1'b1;
                        res.grant_address = model_base + 32'(first * BLOCK_BYTES);
                        live_grants.push_back(res.grant_address);
                        break;
                    end
                end
            end
        end
        else if (addr != 0 && addr >= model_base)
        begin
            off = addr - model_base;
            idx = off / BLOCK_BYTES;
            if (off % BLOCK_BYTES == 0 && idx < NBLK && mark_map[idx] == MARK_START)
            begin
                mark_map[idx] = MARK_FREE;
                idx++;
                while (idx < NBLK && mark_map[idx] == MARK_CONT)
                begin
                    mark_map[idx] = MARK_FREE;
                    idx++;
                end
                res.ok = 1'b1;
            end
        end
        if (!res.ok)
            n_refusals++;
        else if (rtype == REQ_ALLOC)
            n_grants++;
        else
            n_releases++;
        return res;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.req_type     <= REQ_ALLOC;
            req_ch.size_bytes   <= '0;
            req_ch.free_address <= '0;
            req_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(serve_request(req_ch.req_type, req_ch.size_bytes,
                                                      req_ch.free_address));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_ch.req_type     <= pending_reqs[0].req_type;
                    req_ch.size_bytes   <= pending_reqs[0].size_bytes;
                    req_ch.free_address <= pending_reqs[0].free_address;
                    req_ch.valid        <= 1'b1;
                    void'(pending_reqs.pop_front());
                    if ($urandom_range(0, 39) == 0)
                        req_quiet = !req_quiet;
                    req_gap = req_quiet ? 0 : $urandom_range(0, 10);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_wait = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected word: ok %0d grant_address %h",
                           rsp_ch.ok, rsp_ch.grant_address);
                    errors++;
                end
                else
                begin
                    if (rsp_ch.ok !== expected_rsps[0].ok)
                    begin
                        $error("ok: expected %0d, got %0d", expected_rsps[0].ok, rsp_ch.ok);
                        errors++;
                    end
                    if (rsp_ch.grant_address !== expected_rsps[0].grant_address)
                    begin
                        $error("grant_address: expected %h, got %h",
                               expected_rsps[0].grant_address, rsp_ch.grant_address);
                        errors++;
                    end
                    void'(expected_rsps.pop_front());
                end
                if ($urandom_range(0, 39) == 0)
                    rsp_quiet = !rsp_quiet;
                rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 10);
            end
            if (rsp_wait > 0)
            begin
                rsp_wait--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("first_fit_block_allocator_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic issue(logic rtype, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        alloc_req_t w;
        w.req_type     = rtype;
        w.size_bytes   = size;
        w.free_address = addr;
        while (pending_reqs.size() >= 2)
            @(negedge clk);
        pending_reqs.push_back(w);
    endtask

    task automatic issue_alloc(logic [SIZE_W-1:0] size);
        issue(REQ_ALLOC, size, $urandom);
    endtask

    task automatic issue_free(logic [ADDR_W-1:0] addr);
        issue(REQ_FREE, SIZE_W'($urandom_range(0, 65535)), addr);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_pool_base(logic [ADDR_W-1:0] value);
        drain();
        @(posedge clk);
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        model_base = value;
        n_bases++;
        @(negedge clk);
    endtask

    task automatic short_directed();
        issue_free(model_base - BLOCK_BYTES);
        issue_free(model_base + 8);
        issue_free(model_base + NBLK * BLOCK_BYTES);
        issue_alloc(SIZE_W'(POOL_BYTES));
        issue_alloc(16'd1);
    endtask

    task automatic random_phase(int count);
        int                roll;
        int                pick;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) == 0)
                drain();
            roll = $urandom_range(0, 99);
            if (roll < 52)
            begin
                case ($urandom_range(0, 19))
                    0:       size = '0;
                    1:       size = SIZE_W'($urandom_range(POOL_BYTES + 1, 65535));
                    2:       size = SIZE_W'(POOL_BYTES);
                    3, 4, 5: size = SIZE_W'($urandom_range(1, POOL_BYTES));
                    6, 7, 8: size = SIZE_W'($urandom_range(1, 512));
                    default: size = SIZE_W'($urandom_range(1, 96));
                endcase
                issue_alloc(size);
            end
            else if (roll < 88 && live_grants.size() > 0)
            begin
                pick = $urandom_range(0, live_grants.size() - 1);
                addr = live_grants[pick];
                live_grants.delete(pick);
                issue_free(addr);
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0: addr = '0;
                    1: addr = $urandom;
                    2: addr = model_base + $urandom_range(1, BLOCK_BYTES - 1);
                    3: addr = model_base - BLOCK_BYTES * $urandom_range(1, 4);
                    4: addr = model_base + BLOCK_BYTES * $urandom_range(NBLK, NBLK + 8);
                    5: addr = model_base + BLOCK_BYTES * $urandom_range(0, NBLK - 1);
                    default:
                        addr = (live_grants.size() > 0) ?
                               live_grants[$urandom_range(0, live_grants.size() - 1)] +
                               BLOCK_BYTES : model_base;
                endcase
                issue_free(addr);
            end
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type     = REQ_ALLOC;
        req_ch.size_bytes   = '0;
        req_ch.free_address = '0;
        rsp_ch.ready = 1'b0;
        model_base   = '0;
        errors       = 0;
        n_grants     = 0;
        n_releases   = 0;
        n_refusals   = 0;
        n_bases      = 1;
        req_quiet    = 1'b0;
        rsp_quiet    = 1'b0;
        idle_cycles  = 0;
        foreach (mark_map[k])
            mark_map[k] = MARK_FREE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pool based at zero after reset
        issue_alloc(16'd0);
        issue_alloc(16'd1);
        issue_alloc(16'd16);
        issue_alloc(16'd17);
        issue_free(0);
        issue_free(16);
        issue_free(16);
        issue_free(48);
        issue_free(40);
        issue_free(NBLK * BLOCK_BYTES);
        issue_free(32'hFFFF_FFFF);
        issue_alloc(SIZE_W'(POOL_BYTES + 1));
        issue_alloc(16'hFFFF);
        issue_alloc(SIZE_W'(POOL_BYTES));
        issue_free(32);
        issue_alloc(SIZE_W'(POOL_BYTES - BLOCK_BYTES));
        issue_alloc(16'd1);
        issue_free(16);
        random_phase(PHASE_WORDS);

        write_pool_base(32'h0001_0000);
        short_directed();
        random_phase(PHASE_WORDS);

        // grants wrap past the top of the address space
        write_pool_base(32'hFFFF_F800);
        short_directed();
        random_phase(PHASE_WORDS);

        write_pool_base(32'hFFFF_FFFF);
        short_directed();
        random_phase(PHASE_WORDS);

        write_pool_base($urandom);
        short_directed();
        random_phase(PHASE_WORDS);

        write_pool_base(32'h0000_0000);
        short_directed();
        random_phase(PHASE_WORDS);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d requests over %0d pool bases", 
                 n_grants + n_releases + n_refusals, n_bases);
        $display("  %0d grants, %0d releases, %0d refused", n_grants, n_releases, n_refusals);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("first_fit_block_allocator_tb OK");
        else
            $display("first_fit_block_allocator_tb NOT OK");
        $finish;
    end

endmodule

/* first_fit_block_allocator.f */
src/ffba_pkg.sv
src/ffba_if.sv
src/ffba_front.sv
src/ffba_queue.sv
src/ffba_back.sv
src/first_fit_block_allocator.sv
test/first_fit_block_allocator_tb.sv
